[design/epoch_seconds_to_local_calendar_macros.svh]
// Assertion macros shared by the calendar readout RTL.
`ifndef EPOCH_SECONDS_TO_LOCAL_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_LOCAL_CALENDAR_MACROS_SVH

// Checks that cons holds in the same cycle as ante.
`define ESC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante.
`define ESC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/esc_pkg.sv]
// Constants and helpers for the epoch seconds to local calendar pipeline.
package esc_pkg;

  localparam logic [16:0] DAY_SECS     = 17'd86400;
  localparam logic [11:0] HOUR_SECS    = 12'd3600;
  localparam logic [5:0]  MIN_SECS     = 6'd60;
  localparam logic [9:0]  QUARTER_SECS = 10'd900;

  // 86400 = 128 * 675: the low seven bits are dropped and the rest divided by 675.
  localparam int          DAY_SHIFT       = 7;
  localparam int          DAY_RECIP_SHIFT = 40;
  localparam logic [30:0] DAY_RECIP       = 31'((64'd1 << 40) / 64'd675);

  localparam int          RECIP_SHIFT = 32;
  localparam logic [21:0] QUAD_RECIP  = 22'((64'd1 << 32) / 64'd1461);
  localparam logic [20:0] HOUR_RECIP  = 21'((64'd1 << 32) / 64'd3600);
  localparam logic [26:0] MIN_RECIP   = 27'((64'd1 << 32) / 64'd60);

  // Dates are counted from 1968-01-01 so that each four-year cycle opens with a leap year.
  localparam logic [11:0] BASE_YEAR       = 12'd1968;
  localparam logic [9:0]  BASE_TO_EPOCH   = 10'd731;
  localparam logic [10:0] QUAD_DAYS       = 11'd1461;
  localparam logic [8:0]  YEAR1_START     = 9'd366;
  localparam logic [9:0]  YEAR2_START     = 10'd731;
  localparam logic [10:0] YEAR3_START     = 11'd1096;
  // Day count of 2100-03-01. The year 2100 has no Feb 29, so one day is
  // inserted from here on to keep the four-year cycle regular.
  localparam logic [15:0] SKIP_DAY        = 16'd47541;

  localparam logic [3:0]  MONTHS_M1 = 4'd11;

  // First day of zero-based month m within the year.
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
    logic [8:0] base;
    case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && m >= 4'd2) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

[design/esc_day_split.sv]
// Three-stage split of the local second count into whole days and time of day.
module esc_day_split import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] local_secs,
  output logic        out_valid,
  output logic [15:0] days,
  output logic [16:0] tod
);

  logic        v2_r, v3_r, v4_r;
  logic [55:0] prod_r, prod_nxt;
  logic [31:0] loc2_r;
  logic [15:0] qd_r, qd_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [15:0] days_r, days_nxt;
  logic [16:0] tod_r, tod_nxt;
  logic [32:0] qmul;
  logic [31:0] diff;

  always_comb begin
    prod_nxt = 56'(local_secs[31:DAY_SHIFT]) * 56'(DAY_RECIP);
  end

  // The reciprocal estimate can fall short by one, so the remainder lies below two days.
  always_comb begin
    qd_nxt  = prod_r[DAY_RECIP_SHIFT +: 16];
    qmul    = 33'(qd_nxt) * 33'(DAY_SECS);
    diff    = loc2_r - qmul[31:0];
    rem_nxt = diff[17:0];
  end

  always_comb begin
    if (rem_r >= 18'(DAY_SECS)) begin
      days_nxt = qd_r + 16'd1;
      tod_nxt  = 17'(rem_r - 18'(DAY_SECS));
    end else begin
      days_nxt = qd_r;
      tod_nxt  = rem_r[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v2_r <= in_valid;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      loc2_r <= local_secs;
      qd_r   <= qd_nxt;
      rem_r  <= rem_nxt;
      days_r <= days_nxt;
      tod_r  <= tod_nxt;
    end
  end

  assign out_valid = v4_r;
  assign days      = days_r;
  assign tod       = tod_r;

endmodule

[design/epoch_seconds_to_local_calendar.sv]
// Top level of the epoch seconds to local calendar readout pipeline.
// A request carries a 32-bit count of seconds since 1970-01-01 UTC; the
// configured offset in quarter hours is added modulo 2^32 and the local
// year, month, day, hour, minute and second come out of the last stage.
// The pipeline has eleven register stages, built from multiplications by
// constant reciprocals, compare-and-subtract corrections and table lookups,
// and takes a new request every cycle while the result side does not
// stall. A stall on the result side holds the whole pipeline.
// Write the offset only while no request is in flight.
`include "epoch_seconds_to_local_calendar_macros.svh"

module epoch_seconds_to_local_calendar import esc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic signed [6:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       in_epoch_seconds,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [11:0]       out_year,
  output logic [3:0]        out_month,
  output logic [4:0]        out_day_of_month,
  output logic [4:0]        out_hour,
  output logic [5:0]        out_minute,
  output logic [5:0]        out_second
);

  logic              en;
  logic signed [6:0] tz_r;
  logic signed [16:0] off;
  logic [31:0]       loc1_r, loc1_nxt;
  logic              v1_r, v4, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r, v11_r;
  logic [15:0]       days4;
  logic [16:0]       tod4;

  // stage 5
  logic [15:0] d5_r, d5_nxt;
  logic [37:0] ph5_r, ph5_nxt;
  logic [16:0] tod5_r;
  // stage 6
  logic [37:0] pc6_r, pc6_nxt;
  logic [15:0] d6_r;
  logic [4:0]  h6_r, h6_nxt;
  logic [12:0] hrem6_r, hrem6_nxt;
  logic [16:0] hmul;
  // stage 7
  logic [5:0]  c7_r, c7_nxt;
  logic [11:0] cr7_r, cr7_nxt;
  logic [4:0]  hour7_r, hour7_nxt;
  logic [11:0] mrem7_r, mrem7_nxt;
  logic [15:0] cmul;
  // stage 8
  logic [5:0]  c8_r, c8_nxt;
  logic [10:0] r8_r, r8_nxt;
  logic [38:0] pm8_r, pm8_nxt;
  logic [11:0] mrem8_r;
  logic [4:0]  hour8_r;
  // stage 9
  logic [11:0] year9_r, year9_nxt;
  logic [8:0]  doy9_r, doy9_nxt;
  logic        leap9_r, leap9_nxt;
  logic [5:0]  m9_r, m9_nxt;
  logic [6:0]  srem9_r, srem9_nxt;
  logic [4:0]  hour9_r;
  logic [1:0]  yo;
  logic [11:0] mmul;
  // stage 10
  logic [3:0]  mon10_r, mon10_nxt;
  logic [5:0]  min10_r, min10_nxt;
  logic [5:0]  sec10_r, sec10_nxt;
  logic [11:0] year10_r;
  logic [8:0]  doy10_r;
  logic        leap10_r;
  logic [4:0]  hour10_r;
  // output stage
  logic [11:0] year11_r;
  logic [3:0]  month11_r, month11_nxt;
  logic [4:0]  day11_r, day11_nxt;
  logic [4:0]  hour11_r;
  logic [5:0]  min11_r, sec11_r;
  logic [8:0]  dom_nxt;

  assign en       = !(v11_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tz_r <= 7'sd0;
    end else if (cfg_wr_en) begin
      tz_r <= cfg_wr_data;
    end
  end

  always_comb begin
    off      = 17'(signed'({{10{tz_r[6]}}, tz_r})) * signed'(17'(QUARTER_SECS));
    loc1_nxt = in_epoch_seconds + {{15{off[16]}}, off};
  end

  esc_day_split u_day_split (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (v1_r),
    .local_secs (loc1_r),
    .out_valid  (v4),
    .days       (days4),
    .tod        (tod4)
  );

  // Days from 1968-01-01, with the missing Feb 29 of 2100 put back in.
  always_comb begin
    d5_nxt  = days4 + 16'(BASE_TO_EPOCH) + ((days4 >= SKIP_DAY) ? 16'd1 : 16'd0);
    ph5_nxt = 38'(tod4) * 38'(HOUR_RECIP);
  end

  always_comb begin
    pc6_nxt   = 38'(d5_r) * 38'(QUAD_RECIP);
    h6_nxt    = ph5_r[RECIP_SHIFT +: 5];
    hmul      = 17'(h6_nxt) * 17'(HOUR_SECS);
    hrem6_nxt = 13'(tod5_r - hmul);
  end

  always_comb begin
    c7_nxt  = pc6_r[RECIP_SHIFT +: 6];
    cmul    = 16'(c7_nxt) * 16'(QUAD_DAYS);
    cr7_nxt = 12'(d6_r - cmul);
    if (hrem6_r >= 13'(HOUR_SECS)) begin
      hour7_nxt = h6_r + 5'd1;
      mrem7_nxt = 12'(hrem6_r - 13'(HOUR_SECS));
    end else begin
      hour7_nxt = h6_r;
      mrem7_nxt = hrem6_r[11:0];
    end
  end

  always_comb begin
    if (cr7_r >= 12'(QUAD_DAYS)) begin
      c8_nxt = c7_r + 6'd1;
      r8_nxt = 11'(cr7_r - 12'(QUAD_DAYS));
    end else begin
      c8_nxt = c7_r;
      r8_nxt = cr7_r[10:0];
    end
    pm8_nxt = 39'(mrem7_r) * 39'(MIN_RECIP);
  end

  always_comb begin
    if (r8_r < 11'(YEAR1_START)) begin
      yo       = 2'd0;
      doy9_nxt = r8_r[8:0];
    end else if (r8_r < 11'(YEAR2_START)) begin
      yo       = 2'd1;
      doy9_nxt = 9'(r8_r - 11'(YEAR1_START));
    end else if (r8_r < YEAR3_START) begin
      yo       = 2'd2;
      doy9_nxt = 9'(r8_r - 11'(YEAR2_START));
    end else begin
      yo       = 2'd3;
      doy9_nxt = 9'(r8_r - YEAR3_START);
    end
    leap9_nxt = (yo == 2'd0);
    year9_nxt = BASE_YEAR + 12'({c8_r, 2'b00}) + 12'(yo);
    m9_nxt    = pm8_r[RECIP_SHIFT +: 6];
    mmul      = 12'(m9_nxt) * 12'(MIN_SECS);
    srem9_nxt = 7'(mrem8_r - mmul);
  end

  always_comb begin
    mon10_nxt = 4'd0;
    for (int m = 1; m <= 11; m++) begin
      if (doy9_r >= month_start(leap9_r, 4'(m))) begin
        mon10_nxt = mon10_nxt + 4'd1;
      end
    end
    if (srem9_r >= 7'(MIN_SECS)) begin
      min10_nxt = m9_r + 6'd1;
      sec10_nxt = 6'(srem9_r - 7'(MIN_SECS));
    end else begin
      min10_nxt = m9_r;
      sec10_nxt = srem9_r[5:0];
    end
  end

  always_comb begin
    dom_nxt     = doy10_r - month_start(leap10_r, mon10_r) + 9'd1;
    day11_nxt   = dom_nxt[4:0];
    month11_nxt = mon10_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
    end else if (en) begin
      v1_r  <= in_valid;
      v5_r  <= v4;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      loc1_r    <= loc1_nxt;
      d5_r      <= d5_nxt;
      ph5_r     <= ph5_nxt;
      tod5_r    <= tod4;
      pc6_r     <= pc6_nxt;
      d6_r      <= d5_r;
      h6_r      <= h6_nxt;
      hrem6_r   <= hrem6_nxt;
      c7_r      <= c7_nxt;
      cr7_r     <= cr7_nxt;
      hour7_r   <= hour7_nxt;
      mrem7_r   <= mrem7_nxt;
      c8_r      <= c8_nxt;
      r8_r      <= r8_nxt;
      pm8_r     <= pm8_nxt;
      mrem8_r   <= mrem7_r;
      hour8_r   <= hour7_r;
      year9_r   <= year9_nxt;
      doy9_r    <= doy9_nxt;
      leap9_r   <= leap9_nxt;
      m9_r      <= m9_nxt;
      srem9_r   <= srem9_nxt;
      hour9_r   <= hour8_r;
      mon10_r   <= mon10_nxt;
      min10_r   <= min10_nxt;
      sec10_r   <= sec10_nxt;
      year10_r  <= year9_r;
      doy10_r   <= doy9_r;
      leap10_r  <= leap9_r;
      hour10_r  <= hour9_r;
      year11_r  <= year10_r;
      month11_r <= month11_nxt;
      day11_r   <= day11_nxt;
      hour11_r  <= hour10_r;
      min11_r   <= min10_r;
      sec11_r   <= sec10_r;
    end
  end

  assign out_valid        = v11_r;
  assign out_year         = year11_r;
  assign out_month        = month11_r;
  assign out_day_of_month = day11_r;
  assign out_hour         = hour11_r;
  assign out_minute       = min11_r;
  assign out_second       = sec11_r;

  `ESC_ASSERT_NOW(a_time_range, out_valid, (out_hour <= 5'd23) && (out_minute <= 6'd59) && (out_second <= 6'd59), "time of day out of range")
  `ESC_ASSERT_NOW(a_date_range, out_valid, (out_month >= 4'd1) && (out_month <= 4'd12) && (out_day_of_month >= 5'd1) && (out_year >= 12'd1970) && (out_year <= 12'd2106), "date out of range")
  `ESC_ASSERT_NOW(a_feb_days, out_valid && (out_month == 4'd2), out_day_of_month <= 5'd29, "February day out of range")
  `ESC_ASSERT_NEXT(a_take_request, in_valid && !in_stall, v1_r, "accepted request did not enter the pipeline")

endmodule
